>>> hdl/u8d_pkg.sv
package u8d_pkg;

  // Decoder state carried from one byte to the next.
  typedef struct packed {
    logic [31:0] acc;
    logic [2:0]  owed;
    logic [3:0]  taken;
  } u8d_state_t;

  // One decoded character, qualified by valid.
  typedef struct packed {
    logic        valid;
    logic [31:0] code_point;
    logic [3:0]  byte_count;
    logic        truncated;
  } u8d_result_t;

  localparam u8d_state_t U8D_IDLE = '{acc: 32'd0, owed: 3'd0, taken: 4'd0};

  // Number of leading ones in a byte, 0 to 8.
  function automatic logic [3:0] lead_ones(input logic [7:0] b);
    logic [3:0] n;
    casez (b)
      8'b0???????: n = 4'd0;
      8'b10??????: n = 4'd1;
      8'b110?????: n = 4'd2;
      8'b1110????: n = 4'd3;
      8'b11110???: n = 4'd4;
      8'b111110??: n = 4'd5;
      8'b1111110?: n = 4'd6;
      8'b11111110: n = 4'd7;
      default:     n = 4'd8;
    endcase
    return n;
  endfunction

endpackage

>>> hdl/u8d_step.sv
module u8d_step
  import u8d_pkg::*;
(
  input  logic [7:0]  data_byte,
  input  logic        buffer_end,
  input  u8d_state_t  state,
  output u8d_state_t  state_nxt,
  output u8d_result_t result
);

  logic [3:0]  ones;
  logic [2:0]  lead_owed;
  logic [7:0]  lead_payload;
  logic [31:0] acc_shift;
  logic [3:0]  taken_inc;
  logic [2:0]  owed_dec;

  // Lead byte analysis: owed bytes and the payload bits it keeps.
  assign ones         = lead_ones(data_byte);
  assign lead_owed    = (ones >= 4'd2) ? 3'(ones - 4'd1) : 3'd0;
  assign lead_payload = data_byte & (8'h3F >> lead_owed);

  // Following byte: shift six bits into the accumulator.
  assign acc_shift = {state.acc[25:0], data_byte[5:0]};
  assign taken_inc = state.taken + 4'd1;
  assign owed_dec  = state.owed - 3'd1;

  // Next state and the result of this byte.
  always_comb begin
    state_nxt = state;
    result    = '{valid: 1'b0, code_point: 32'd0, byte_count: 4'd1, truncated: 1'b0};
    if (state.owed == 3'd0) begin
      if (!data_byte[7]) begin
        result.valid      = 1'b1;
        result.code_point = {24'd0, data_byte};
      end else if (lead_owed == 3'd0) begin
        result.valid      = 1'b1;
        result.code_point = {24'd0, lead_payload};
      end else if (buffer_end) begin
        result.valid     = 1'b1;
        result.truncated = 1'b1;
        state_nxt        = U8D_IDLE;
      end else begin
        state_nxt = '{acc: {24'd0, lead_payload}, owed: lead_owed, taken: 4'd1};
      end
    end else begin
      if (owed_dec == 3'd0) begin
        result.valid      = 1'b1;
        result.code_point = acc_shift;
        result.byte_count = taken_inc;
        state_nxt         = U8D_IDLE;
      end else if (buffer_end) begin
        result.valid      = 1'b1;
        result.byte_count = taken_inc;
        result.truncated  = 1'b1;
        state_nxt         = U8D_IDLE;
      end else begin
        state_nxt = '{acc: acc_shift, owed: owed_dec, taken: taken_inc};
      end
    end
  end

endmodule

>>> hdl/utf8_stream_code_point_decoder_core.sv
// UTF-8 byte stream decoder: takes one byte per cycle and delivers one code point per
// finished character, with the byte count and a truncation flag when a buffer ends
// while continuation bytes are still owed. A byte is taken in every cycle while the
// result side keeps up; a result is registered after its last byte is accepted (the
// byte sits in the input register, then the result register loads). The accumulator
// and owed-byte count update as each byte moves on, setting the one-byte-per-cycle rate.
module utf8_stream_code_point_decoder_core
  import u8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_buffer_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_code_point,
  output logic [3:0]  out_byte_count,
  output logic        out_truncated
);

  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_byte_r;
  logic        s1_end_r;
  u8d_state_t  state_r, state_nxt;
  u8d_result_t result;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_code_point_r;
  logic [3:0]  out_byte_count_r;
  logic        out_truncated_r;
  logic        out_free, s1_go, in_take;

  u8d_step u_step (
    .data_byte  (s1_byte_r),
    .buffer_end (s1_end_r),
    .state      (state_r),
    .state_nxt  (state_nxt),
    .result     (result)
  );

  // Handshake: a held byte moves on unless it has a result and the result slot is full.
  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && (!result.valid || out_free);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_take  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = (s1_go && result.valid) ? 1'b1 : (out_free ? 1'b0 : out_valid_r);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= U8D_IDLE;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_go) begin
        state_r <= state_nxt;
      end
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_data_byte;
      s1_end_r  <= in_buffer_end;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (s1_go && result.valid) begin
      out_code_point_r <= result.code_point;
      out_byte_count_r <= result.byte_count;
      out_truncated_r  <= result.truncated;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_code_point = out_code_point_r;
  assign out_byte_count = out_byte_count_r;
  assign out_truncated  = out_truncated_r;

endmodule
